// ===== rtl/tsir_pkg.sv =====
package tsir_pkg;

  // Function codes carried in the input tuser field.
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_KEY   = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // Register bit offsets.
  localparam logic [3:0] OFF_RECV      = 4'd0;
  localparam logic [3:0] OFF_STATUS    = 4'd1;
  localparam logic [3:0] OFF_XMIT_LAST = 4'd7;
  localparam logic [3:0] OFF_DTR       = 4'd9;
  localparam logic [3:0] OFF_RTS       = 4'd10;
  localparam logic [3:0] OFF_CLR_WRQ   = 4'd11;
  localparam logic [3:0] OFF_CLR_RRQ   = 4'd12;
  localparam logic [3:0] OFF_CLR_NEW   = 4'd13;
  localparam logic [3:0] OFF_INT_EN    = 4'd14;
  localparam logic [3:0] OFF_DIAG      = 4'd15;

  // Printer line.
  localparam int unsigned COL_W = 7;
  localparam logic [COL_W-1:0] LINE_COLUMNS = 7'd80;

  // Character codes.
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  // One result beat, lowest field last in the declaration so that it packs low.
  typedef struct packed {
    logic             line_advance;
    logic [COL_W-1:0] print_column;
    logic [6:0]       print_char;
    logic             print_strobe;
    logic             irq_level;
    logic [7:0]       read_data;
  } result_t;

endpackage

// ===== rtl/tty_serial_interface_registers_unit.sv =====
// Bit-addressed terminal interface register unit.
//
// The input channel carries one bus access per beat: a register read, a single
// register bit write, or a keyboard character arriving. The function code is in
// in_tuser; the offset, write bit and key character are in in_tdata. Every input
// beat produces exactly one result beat on the output channel carrying the read
// data, the interrupt level after the access, and the printer strobes (print
// strobe with character and column, and line advance).
//
// The register update and the result are formed by short logic in the cycle the
// beat is accepted, and the result is registered; one beat can be taken in every
// cycle while in_tready is high.
// The output register is backed by a one-entry skid stage: a new input beat is
// still taken while a result waits, and in_tready falls only once the skid
// stage is full, i.e. after the receiver has stalled for a whole beat.
//
// Reset (rst_n low, synchronous) empties both output stages and returns the
// registers to their initial values: status with DSR and WRQ set, everything
// else clear, printer column zero.
module tty_serial_interface_registers_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [3:0] bit_offset, [4] write_bit, [12:5] key_char, [15:13] zero
  input  logic [tsir_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] func
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] read_data, [8] irq_level, [9] print_strobe, [16:10] print_char,
  // [23:17] print_column, [24] line_advance, [31:25] zero
  output logic [tsir_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import tsir_pkg::*;

  // Architectural state. DSR is constant one and the status INT bit always
  // mirrors the interrupt level, so neither has a register of its own. The
  // diagnostic mode bit is stored but has no effect on any output.
  logic [7:0]       recv_char_r, recv_char_nxt;
  logic [7:0]       xmit_byte_r, xmit_byte_nxt;
  logic             wrq_r, wrq_nxt;
  logic             rrq_r, rrq_nxt;
  logic             dtr_r, dtr_nxt;
  logic             rts_r, rts_nxt;
  logic             int_en_r, int_en_nxt;
  logic             diag_r, diag_nxt;
  logic             new_status_r, new_status_nxt;
  logic [COL_W-1:0] column_r, column_nxt;

  // Output register and skid stage.
  result_t out_data_r, skid_data_r;
  logic    out_valid_r, skid_valid_r;

  result_t res;
  func_t   func;
  logic [3:0] bit_offset;
  logic       write_bit;
  logic [7:0] key_char;
  logic       in_fire, out_fire;

  assign func       = func_t'(in_tuser);
  assign bit_offset = in_tdata[3:0];
  assign write_bit  = in_tdata[4];
  assign key_char   = in_tdata[12:5];

  assign in_tready  = !skid_valid_r;
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_data_r};

  // Register update and result for the beat on the input.
  always_comb begin
    logic [7:0]       sent;
    logic [COL_W-1:0] place;
    recv_char_nxt  = recv_char_r;
    xmit_byte_nxt  = xmit_byte_r;
    wrq_nxt        = wrq_r;
    rrq_nxt        = rrq_r;
    dtr_nxt        = dtr_r;
    rts_nxt        = rts_r;
    int_en_nxt     = int_en_r;
    diag_nxt       = diag_r;
    new_status_nxt = new_status_r;
    column_nxt     = column_r;
    res            = '0;
    sent           = xmit_byte_r;
    place          = column_r;

    unique case (func)
      FUNC_READ: begin
        if (bit_offset == OFF_RECV) begin
          res.read_data = recv_char_r;
        end else if (bit_offset == OFF_STATUS) begin
          // INT, DSR, unused, RRQ, WRQ, three unused bits.
          res.read_data = {int_en_r && new_status_r, 1'b1, 1'b0, rrq_r, wrq_r, 3'b000};
        end
      end
      FUNC_WRITE: begin
        if (!bit_offset[3]) begin
          xmit_byte_nxt[bit_offset[2:0]] = write_bit;
          sent = xmit_byte_nxt;
          // The top bit completes the byte; it goes out only with DTR and RTS.
          if (bit_offset == OFF_XMIT_LAST && dtr_r && rts_r) begin
            if (sent == CH_BS) begin
              if (column_r != '0) begin
                column_nxt = column_r - COL_W'(1);
              end
            end else if (sent == CH_LF) begin
              res.line_advance = 1'b1;
            end else if (sent == CH_CR) begin
              column_nxt = '0;
            end else if (sent >= CH_SPACE && sent < CH_DEL) begin
              // Wrap at the end of the line: new line, character at column zero.
              if (column_r >= LINE_COLUMNS) begin
                place            = '0;
                res.line_advance = 1'b1;
              end
              res.print_strobe = 1'b1;
              res.print_char   = sent[6:0];
              res.print_column = place;
              column_nxt       = place + COL_W'(1);
            end
            wrq_nxt        = 1'b1;
            new_status_nxt = 1'b1;
          end
        end else begin
          unique case (bit_offset)
            OFF_DTR:     dtr_nxt        = write_bit;
            OFF_RTS:     rts_nxt        = write_bit;
            OFF_INT_EN:  int_en_nxt     = write_bit;
            OFF_DIAG:    diag_nxt       = write_bit;
            OFF_CLR_WRQ: wrq_nxt        = 1'b0;
            OFF_CLR_RRQ: rrq_nxt        = 1'b0;
            OFF_CLR_NEW: new_status_nxt = 1'b0;
            default:     ;
          endcase
        end
      end
      FUNC_KEY: begin
        // A character arriving while the previous one is unread is dropped.
        if (!rrq_r) begin
          recv_char_nxt  = key_char;
          rrq_nxt        = 1'b1;
          new_status_nxt = 1'b1;
        end
      end
      FUNC_NOP: ;
      default: ;
    endcase

    res.irq_level = int_en_nxt && new_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_char_r  <= '0;
      xmit_byte_r  <= '0;
      wrq_r        <= 1'b1;
      rrq_r        <= 1'b0;
      dtr_r        <= 1'b0;
      rts_r        <= 1'b0;
      int_en_r     <= 1'b0;
      diag_r       <= 1'b0;
      new_status_r <= 1'b0;
      column_r     <= '0;
    end else if (in_fire) begin
      recv_char_r  <= recv_char_nxt;
      xmit_byte_r  <= xmit_byte_nxt;
      wrq_r        <= wrq_nxt;
      rrq_r        <= rrq_nxt;
      dtr_r        <= dtr_nxt;
      rts_r        <= rts_nxt;
      int_en_r     <= int_en_nxt;
      diag_r       <= diag_nxt;
      new_status_r <= new_status_nxt;
      column_r     <= column_nxt;
    end
  end

  // Output register with skid stage. The skid stage fills only when a beat is
  // taken while the output register is occupied and not being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

  // The skid stage is only ever occupied behind a waiting output beat.
  assert property (@(posedge clk) disable iff (!rst_n) skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while the output register is empty");

  // The printer column never runs past the end of the line.
  assert property (@(posedge clk) disable iff (!rst_n) column_r <= LINE_COLUMNS)
    else $error("printer column beyond the line length");

  // A placed character always lands inside the line.
  assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_data_r.print_strobe) |-> (out_data_r.print_column < LINE_COLUMNS))
    else $error("character placed beyond the line length");

  // A full, undrained output side keeps the input side stopped in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
      (skid_valid_r && !out_tready) |=> !in_tready)
    else $error("input accepted while both output stages are full");

endmodule

// ===== tb/tsir_result_checker.sv =====
`timescale 1ns / 1ps

module tsir_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [3:0] bit_offset, [4] write_bit, [12:5] key_char, [15:13] zero
  input  logic [tsir_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] func
  input  logic [1:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] read_data, [8] irq_level, [9] print_strobe, [16:10] print_char,
  // [23:17] print_column, [24] line_advance, [31:25] zero
  input  logic [tsir_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              mismatches,
  output int                              results_seen
);
  import tsir_pkg::*;

  // Bit positions in the status and mode bytes.
  localparam int ST_WRQ = 3;
  localparam int ST_RRQ = 4;
  localparam int ST_DSR = 6;
  localparam int ST_INT = 7;
  localparam int MD_DTR = 1;
  localparam int MD_RTS = 2;
  localparam int MD_EN  = 6;
  localparam int RES_W  = $bits(result_t);

  logic [7:0] rx_byte;
  logic [7:0] tx_byte;
  logic [7:0] status_reg;
  logic [7:0] mode_reg;
  logic       new_flag;
  logic [6:0] head_col;

  result_t awaited_results[$];
  result_t want;
  result_t got;

  // Applies one bus access to the register copy and returns the beat it causes.
  function automatic result_t apply_access(func_t f, logic [3:0] off, logic wbit,
                                           logic [7:0] key);
    result_t r;
    logic    irq;
    r = '0;
    case (f)
      FUNC_READ: begin
        if (off == OFF_RECV) r.read_data = rx_byte;
        else if (off == OFF_STATUS) r.read_data = status_reg;
      end
      FUNC_WRITE: begin
        if (!off[3]) begin
          tx_byte[off[2:0]] = wbit;
          if (off == OFF_XMIT_LAST && mode_reg[MD_DTR] && mode_reg[MD_RTS]) begin
            if (tx_byte == CH_BS) begin
              if (head_col != 7'd0) head_col = head_col - 7'd1;
            end else if (tx_byte == CH_LF) begin
              r.line_advance = 1'b1;
            end else if (tx_byte == CH_CR) begin
              head_col = '0;
            end else if (tx_byte >= CH_SPACE && tx_byte < CH_DEL) begin
              if (head_col >= LINE_COLUMNS) begin
                head_col       = '0;
                r.line_advance = 1'b1;
              end
              r.print_strobe = 1'b1;
              r.print_char   = tx_byte[6:0];
              r.print_column = head_col;
              head_col       = head_col + 7'd1;
            end
            status_reg[ST_WRQ] = 1'b1;
            new_flag           = 1'b1;
          end
        end else if (off == OFF_DTR || off == OFF_RTS || off == OFF_INT_EN ||
                     off == OFF_DIAG) begin
          mode_reg[off[2:0]] = wbit;
        end else if (off == OFF_CLR_WRQ || off == OFF_CLR_RRQ) begin
          status_reg[off[2:0]] = 1'b0;
        end else if (off == OFF_CLR_NEW) begin
          new_flag = 1'b0;
        end
      end
      FUNC_KEY: begin
        // A full keyboard buffer drops the character.
        if (!status_reg[ST_RRQ]) begin
          rx_byte            = key;
          status_reg[ST_RRQ] = 1'b1;
          new_flag           = 1'b1;
        end
      end
      default: ;
    endcase
    irq                = mode_reg[MD_EN] && new_flag;
    status_reg[ST_INT] = irq;
    r.irq_level        = irq;
    return r;
  endfunction

  task automatic compare_field(string field, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_byte            = '0;
      tx_byte            = '0;
      status_reg         = '0;
      status_reg[ST_DSR] = 1'b1;
      status_reg[ST_WRQ] = 1'b1;
      mode_reg           = '0;
      new_flag           = 1'b0;
      head_col           = '0;
      mismatches         = 0;
      awaited_results.delete();
      results_seen <= 0;
    end else begin
      // A result leaves only after its access has been registered, so the
      // output side is settled before this edge's input beat is predicted.
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual 0x%0h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          got  = out_tdata[RES_W-1:0];
          compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
          compare_field("irq_level", 32'(want.irq_level), 32'(got.irq_level));
          compare_field("print_strobe", 32'(want.print_strobe), 32'(got.print_strobe));
          compare_field("print_char", 32'(want.print_char), 32'(got.print_char));
          compare_field("print_column", 32'(want.print_column), 32'(got.print_column));
          compare_field("line_advance", 32'(want.line_advance), 32'(got.line_advance));
          compare_field("padding", 32'd0, 32'(out_tdata[OUT_DATA_W-1:RES_W]));
        end
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(apply_access(func_t'(in_tuser), in_tdata[3:0],
                                               in_tdata[4], in_tdata[12:5]));
    end
  end

endmodule

// ===== tb/tty_serial_interface_registers_unit_tb.sv =====
`timescale 1ns / 1ps

module tty_serial_interface_registers_unit_tb;
  import tsir_pkg::*;

  // Rough size of the run in accesses, and the points at which the pressure
  // scenarios kick in. The receiver keys off delivered results, the sender off
  // its own accepted beats, so neither depends on the other's process order.
  localparam int ITEMS       = 2000;
  localparam int CALM_FROM   = 1800;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 64;
  localparam int DRAIN_AT    = 1000;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int results_seen;
  int sent_count = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tty_serial_interface_registers_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // The checker watches both channels, predicts every result beat and keeps
  // the mismatch count; this module only makes stimulus and gives the verdict.
  tsir_result_checker u_result_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .mismatches   (mismatches),
    .results_seen (results_seen)
  );

  // Offers one access and waits until the block takes it. Before the beat the
  // sender may idle for a short burst, except in every fourth block of 128
  // beats and in the closing part of the run, which go at full rate.
  task automatic issue(func_t f, logic [3:0] off, logic wbit, logic [7:0] key);
    if (sent_count < CALM_FROM && ((sent_count / 128) % 4) != 3 &&
        $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {3'b000, key, wbit, off};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  // Sends one character to the printer: the transmit byte is built bit by bit
  // and the write to the top bit sends it, provided DTR and RTS are both set.
  // The key field is unused here, so it carries random noise.
  task automatic print_code(logic [7:0] code);
    for (int i = 0; i < 8; i++) issue(FUNC_WRITE, 4'(i), code[i], 8'($urandom));
  endtask

  // A line of text: mostly printable characters, with the odd backspace,
  // delete, line feed or arbitrary byte; a long line runs past the right
  // margin and so exercises the wrap onto a fresh line.
  task automatic print_line(bit long_line);
    int          count;
    int unsigned pick;
    logic [7:0]  code;
    count = long_line ? $urandom_range(82, 90) : $urandom_range(1, 8);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (long_line || pick < 88) code = 8'($urandom_range(CH_SPACE, CH_DEL - 1));
      else if (pick < 93) code = CH_BS;
      else if (pick < 95) code = CH_DEL;
      else if (pick < 97) code = CH_LF;
      else code = 8'($urandom);
      print_code(code);
    end
    if ($urandom_range(0, 1) == 0) begin
      print_code(CH_CR);
      print_code(CH_LF);
    end
  endtask

  // Receiver: a single long hold-off once enough results have come back, so
  // that both output stages fill and the block pushes back on its input;
  // otherwise short random stalls, with quiet stretches and none at the end.
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (results_seen < CALM_FROM && ((results_seen / 96) % 4) != 1 &&
                   $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: a run in which nothing moves on either channel for too long
  // has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    bit drained;
    drained = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= FUNC_NOP;
    in_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: reads straight out of reset, an unused offset and a
    // no-operation beat with every data bit set, a keyboard character and a
    // second one that is dropped because the buffer is still full, the clear
    // strobes (which act whatever bit is written), the ignored offset, a send
    // with DTR and RTS clear (the byte is only stored) and then a backspace
    // sent while the printer sits at column zero.
    issue(FUNC_READ, OFF_RECV, 1'b0, 8'h00);
    issue(FUNC_READ, OFF_STATUS, 1'b0, 8'h00);
    issue(FUNC_READ, 4'hF, 1'b1, 8'hFF);
    issue(FUNC_NOP, 4'hF, 1'b1, 8'hFF);
    issue(FUNC_WRITE, OFF_INT_EN, 1'b1, 8'h00);
    issue(FUNC_KEY, 4'h0, 1'b0, 8'hFF);
    issue(FUNC_KEY, 4'h0, 1'b0, 8'h00);
    issue(FUNC_READ, OFF_RECV, 1'b0, 8'h00);
    issue(FUNC_READ, OFF_STATUS, 1'b0, 8'h00);
    issue(FUNC_WRITE, OFF_CLR_NEW, 1'b0, 8'h00);
    issue(FUNC_WRITE, OFF_CLR_RRQ, 1'b1, 8'h00);
    issue(FUNC_WRITE, OFF_CLR_WRQ, 1'b0, 8'h00);
    issue(FUNC_WRITE, 4'd8, 1'b1, 8'h00);
    issue(FUNC_WRITE, OFF_DIAG, 1'b1, 8'h00);
    issue(FUNC_WRITE, OFF_XMIT_LAST, 1'b1, 8'h00);
    issue(FUNC_WRITE, OFF_DTR, 1'b1, 8'h00);
    issue(FUNC_WRITE, OFF_RTS, 1'b1, 8'h00);
    print_code(CH_BS);

    // Random part. It opens with a long line so that the margin wrap is seen
    // in every run; after that, short and occasional long lines make up most
    // of the traffic, mixed with mode changes, keyboard input, status
    // handling and fully random beats.
    print_line(1'b1);
    while (sent_count < ITEMS) begin
      // Once, the sender stops and lets every outstanding result drain.
      if (!drained && sent_count >= DRAIN_AT) begin
        drained = 1'b1;
        in_tvalid <= 1'b0;
        do @(posedge clk); while (results_seen != sent_count);
      end
      case ($urandom_range(0, 9))
        0, 1, 2: print_line($urandom_range(0, 9) == 0);
        3: begin
          // Mostly re-enable sending; sometimes flip a single mode bit, which
          // may leave later characters stored but never sent.
          if ($urandom_range(0, 3) != 0) begin
            issue(FUNC_WRITE, OFF_DTR, 1'b1, 8'($urandom));
            issue(FUNC_WRITE, OFF_RTS, 1'b1, 8'($urandom));
          end else begin
            case ($urandom_range(0, 3))
              0: issue(FUNC_WRITE, OFF_DTR, 1'($urandom), 8'($urandom));
              1: issue(FUNC_WRITE, OFF_RTS, 1'($urandom), 8'($urandom));
              2: issue(FUNC_WRITE, OFF_INT_EN, 1'($urandom), 8'($urandom));
              default: issue(FUNC_WRITE, OFF_DIAG, 1'($urandom), 8'($urandom));
            endcase
          end
        end
        4, 5: begin
          // A keystroke, usually followed by the handler reading it and
          // freeing the buffer.
          issue(FUNC_KEY, 4'($urandom), 1'($urandom), 8'($urandom));
          if ($urandom_range(0, 2) != 0) begin
            issue(FUNC_READ, OFF_STATUS, 1'($urandom), 8'($urandom));
            issue(FUNC_READ, OFF_RECV, 1'($urandom), 8'($urandom));
            issue(FUNC_WRITE, OFF_CLR_RRQ, 1'($urandom), 8'($urandom));
          end
        end
        6: begin
          issue(FUNC_READ, OFF_STATUS, 1'($urandom), 8'($urandom));
          case ($urandom_range(0, 2))
            0: issue(FUNC_WRITE, OFF_CLR_WRQ, 1'($urandom), 8'($urandom));
            1: issue(FUNC_WRITE, OFF_CLR_RRQ, 1'($urandom), 8'($urandom));
            default: issue(FUNC_WRITE, OFF_CLR_NEW, 1'($urandom), 8'($urandom));
          endcase
        end
        default: issue(func_t'($urandom_range(0, 3)), 4'($urandom), 1'($urandom),
                       8'($urandom));
      endcase
    end

    // Let every result come back, keep watching for any stray beat,
    // and give the verdict away from the clock edge.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_seen != sent_count);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tsir_pkg.sv
rtl/tty_serial_interface_registers_unit.sv
tb/tsir_result_checker.sv
tb/tty_serial_interface_registers_unit_tb.sv
